@@ rtl/psd_pkg.sv @@
// Package for the point-to-segment distance pipeline.
// Holds widths, pipeline stage records and the per-stage step functions.
// No dependencies.
package psd_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int LEN_W   = 2 * DIFF_W;
   localparam int T_FRAC  = 16;
   localparam int T_W     = T_FRAC + 1;
   localparam int ROOT_W  = LEN_W / 2;
   localparam int REM_W   = ROOT_W + 3;
   localparam int PROD_W  = T_W + DIFF_W;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic                 sat_zero;
      logic                 sat_one;
      logic [DIFF_W-1:0]    dx;
      logic [DIFF_W-1:0]    dy;
      logic [COORD_W-1:0]   vx;
      logic [COORD_W-1:0]   vy;
      logic [COORD_W-1:0]   px;
      logic [COORD_W-1:0]   py;
      logic [LEN_W-1:0]     rem;
      logic [LEN_W-1:0]     len2;
      logic [T_W-1:0]       quot;
   } div_stage_type;

   typedef struct packed {
      logic                 valid;
      logic                 degen;
      logic [COORD_W-1:0]   nx;
      logic [COORD_W-1:0]   ny;
      logic [LEN_W-1:0]     rad;
      logic [REM_W-1:0]     rem;
      logic [ROOT_W-1:0]    root;
   } sqrt_stage_type;

   // One restoring division step: one quotient bit.
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type     r;
      logic [LEN_W:0]    rsh;
      r   = s;
      rsh = {s.rem, 1'b0};
      if (rsh >= {1'b0, s.len2}) begin
         r.rem  = LEN_W'(rsh - {1'b0, s.len2});
         r.quot = {s.quot[T_W-2:0], 1'b1};
      end else begin
         r.rem  = rsh[LEN_W-1:0];
         r.quot = {s.quot[T_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One digit-by-digit square root step: one root bit.
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      sqrt_stage_type     r;
      logic [REM_W+1:0]   rsh;
      logic [REM_W+1:0]   trial;
      r     = s;
      rsh   = {s.rem, s.rad[LEN_W-1:LEN_W-2]};
      trial = (REM_W+2)'({s.root, 2'b01});
      r.rad = {s.rad[LEN_W-3:0], 2'b00};
      if (rsh >= trial) begin
         r.rem  = REM_W'(rsh - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rsh[REM_W-1:0];
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

@@ rtl/point_segment_distance_top.sv @@
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg for widths, stage records and step functions.
//
// A new beat is taken in every cycle (busy stays low); each result appears on
// rsp_valid in order. The pipeline holds the 16-stage quotient pipeline for the
// projection parameter and the 25-stage square root pipeline, plus seven stages
// of subtract and multiply.
// The receiver cannot stall, so nothing is held back.
module point_segment_distance_top
   import psd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0]  req_seg_start_x,
   input  logic signed [COORD_W-1:0]  req_seg_start_y,
   input  logic signed [COORD_W-1:0]  req_seg_end_x,
   input  logic signed [COORD_W-1:0]  req_seg_end_y,
   input  logic signed [COORD_W-1:0]  req_query_x,
   input  logic signed [COORD_W-1:0]  req_query_y,
   output logic                       rsp_valid,
   output logic [COORD_W:0]           rsp_distance,
   output logic signed [COORD_W-1:0]  rsp_nearest_x,
   output logic signed [COORD_W-1:0]  rsp_nearest_y,
   output logic                       rsp_degenerate
);

   localparam int DIV_N  = T_FRAC;
   localparam int SQRT_N = ROOT_W;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC - 1);

   logic                        s1_valid_ff;
   logic signed [DIFF_W-1:0]    s1_dx_ff, s1_dy_ff, s1_qx_ff, s1_qy_ff;
   logic [COORD_W-1:0]          s1_vx_ff, s1_vy_ff, s1_px_ff, s1_py_ff;

   logic                        s2_valid_ff;
   logic signed [LEN_W-1:0]     s2_xx_ff, s2_yy_ff, s2_qxd_ff, s2_qyd_ff;
   logic signed [DIFF_W-1:0]    s2_dx_ff, s2_dy_ff;
   logic [COORD_W-1:0]          s2_vx_ff, s2_vy_ff, s2_px_ff, s2_py_ff;

   div_stage_type               div_ff [0:DIV_N];
   div_stage_type               div_in [0:DIV_N];
   logic [LEN_W:0]              len2_in;
   logic signed [LEN_W:0]       dot_in;

   logic [T_W-1:0]              t_in;
   logic                        m1_valid_ff, m1_degen_ff;
   logic signed [PROD_W-1:0]    m1_tx_ff, m1_ty_ff;
   logic [COORD_W-1:0]          m1_vx_ff, m1_vy_ff, m1_px_ff, m1_py_ff;

   logic                        m2_valid_ff, m2_degen_ff;
   logic [COORD_W-1:0]          m2_nx_ff, m2_ny_ff;
   logic signed [DIFF_W-1:0]    m2_ex_ff, m2_ey_ff;
   logic [COORD_W-1:0]          nx_in, ny_in;
   logic signed [PROD_W-1:0]    rx_in, ry_in;

   logic                        m3_valid_ff, m3_degen_ff;
   logic [COORD_W-1:0]          m3_nx_ff, m3_ny_ff;
   logic signed [LEN_W-1:0]     m3_xx_ff, m3_yy_ff;
   logic [LEN_W:0]              rad_in;

   sqrt_stage_type              sq_ff [0:SQRT_N];
   sqrt_stage_type              sq_in [0:SQRT_N];

   assign busy = 1'b0;

   always_comb begin
      len2_in = (LEN_W+1)'(s2_xx_ff) + (LEN_W+1)'(s2_yy_ff);
      dot_in  = (LEN_W+1)'(s2_qxd_ff) + (LEN_W+1)'(s2_qyd_ff);
      div_in[0].valid    = s2_valid_ff && !reset;
      div_in[0].len2     = len2_in[LEN_W-1:0];
      div_in[0].degen    = (len2_in == '0);
      div_in[0].sat_zero = (dot_in <= 0);
      div_in[0].sat_one  = (dot_in >= $signed(len2_in));
      div_in[0].dx       = s2_dx_ff;
      div_in[0].dy       = s2_dy_ff;
      div_in[0].vx       = s2_vx_ff;
      div_in[0].vy       = s2_vy_ff;
      div_in[0].px       = s2_px_ff;
      div_in[0].py       = s2_py_ff;
      div_in[0].rem      = dot_in[LEN_W-1:0];
      div_in[0].quot     = '0;
      for (int k = 1; k <= DIV_N; k++) begin
         div_in[k]       = div_step(div_ff[k-1]);
         div_in[k].valid = div_ff[k-1].valid && !reset;
      end
   end

   always_comb begin
      if (div_ff[DIV_N].degen || div_ff[DIV_N].sat_zero) begin
         t_in = '0;
      end else if (div_ff[DIV_N].sat_one) begin
         t_in = T_W'(1) << T_FRAC;
      end else begin
         t_in = div_ff[DIV_N].quot;
      end
   end

   always_comb begin
      rx_in  = (m1_tx_ff + HALF) >>> T_FRAC;
      ry_in  = (m1_ty_ff + HALF) >>> T_FRAC;
      nx_in  = m1_vx_ff + rx_in[COORD_W-1:0];
      ny_in  = m1_vy_ff + ry_in[COORD_W-1:0];
      rad_in = (LEN_W+1)'(m3_xx_ff) + (LEN_W+1)'(m3_yy_ff);
      sq_in[0].valid = m3_valid_ff && !reset;
      sq_in[0].degen = m3_degen_ff;
      sq_in[0].nx    = m3_nx_ff;
      sq_in[0].ny    = m3_ny_ff;
      sq_in[0].rad   = rad_in[LEN_W-1:0];
      sq_in[0].rem   = '0;
      sq_in[0].root  = '0;
      for (int k = 1; k <= SQRT_N; k++) begin
         sq_in[k]       = sqrt_step(sq_ff[k-1]);
         sq_in[k].valid = sq_ff[k-1].valid && !reset;
      end
   end

   always_ff @(posedge clock) begin
      s1_valid_ff <= start && !reset;
      s1_dx_ff    <= DIFF_W'(req_seg_end_x) - DIFF_W'(req_seg_start_x);
      s1_dy_ff    <= DIFF_W'(req_seg_end_y) - DIFF_W'(req_seg_start_y);
      s1_qx_ff    <= DIFF_W'(req_query_x) - DIFF_W'(req_seg_start_x);
      s1_qy_ff    <= DIFF_W'(req_query_y) - DIFF_W'(req_seg_start_y);
      s1_vx_ff    <= req_seg_start_x;
      s1_vy_ff    <= req_seg_start_y;
      s1_px_ff    <= req_query_x;
      s1_py_ff    <= req_query_y;

      s2_valid_ff <= s1_valid_ff && !reset;
      s2_xx_ff    <= s1_dx_ff * s1_dx_ff;
      s2_yy_ff    <= s1_dy_ff * s1_dy_ff;
      s2_qxd_ff   <= s1_qx_ff * s1_dx_ff;
      s2_qyd_ff   <= s1_qy_ff * s1_dy_ff;
      s2_dx_ff    <= s1_dx_ff;
      s2_dy_ff    <= s1_dy_ff;
      s2_vx_ff    <= s1_vx_ff;
      s2_vy_ff    <= s1_vy_ff;
      s2_px_ff    <= s1_px_ff;
      s2_py_ff    <= s1_py_ff;

      for (int k = 0; k <= DIV_N; k++) begin
         div_ff[k] <= div_in[k];
      end

      m1_valid_ff <= div_ff[DIV_N].valid && !reset;
      m1_degen_ff <= div_ff[DIV_N].degen;
      m1_tx_ff    <= $signed({1'b0, t_in}) * $signed(div_ff[DIV_N].dx);
      m1_ty_ff    <= $signed({1'b0, t_in}) * $signed(div_ff[DIV_N].dy);
      m1_vx_ff    <= div_ff[DIV_N].vx;
      m1_vy_ff    <= div_ff[DIV_N].vy;
      m1_px_ff    <= div_ff[DIV_N].px;
      m1_py_ff    <= div_ff[DIV_N].py;

      m2_valid_ff <= m1_valid_ff && !reset;
      m2_degen_ff <= m1_degen_ff;
      m2_nx_ff    <= nx_in;
      m2_ny_ff    <= ny_in;
      m2_ex_ff    <= DIFF_W'($signed(m1_px_ff)) - DIFF_W'($signed(nx_in));
      m2_ey_ff    <= DIFF_W'($signed(m1_py_ff)) - DIFF_W'($signed(ny_in));

      m3_valid_ff <= m2_valid_ff && !reset;
      m3_degen_ff <= m2_degen_ff;
      m3_nx_ff    <= m2_nx_ff;
      m3_ny_ff    <= m2_ny_ff;
      m3_xx_ff    <= m2_ex_ff * m2_ex_ff;
      m3_yy_ff    <= m2_ey_ff * m2_ey_ff;

      for (int k = 0; k <= SQRT_N; k++) begin
         sq_ff[k] <= sq_in[k];
      end
   end

   assign rsp_valid      = sq_ff[SQRT_N].valid;
   assign rsp_distance   = (COORD_W+1)'(sq_ff[SQRT_N].root);
   assign rsp_nearest_x  = sq_ff[SQRT_N].nx;
   assign rsp_nearest_y  = sq_ff[SQRT_N].ny;
   assign rsp_degenerate = sq_ff[SQRT_N].degen;

`ifndef SYNTHESIS
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      div_ff[DIV_N].valid |-> (t_in <= (T_W'(1) << T_FRAC)))
      else $error("projection parameter above one");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (div_ff[DIV_N].valid && !div_ff[DIV_N].degen && !div_ff[DIV_N].sat_zero &&
       !div_ff[DIV_N].sat_one) |-> (div_ff[DIV_N].rem < div_ff[DIV_N].len2))
      else $error("division remainder not below divisor");

   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      sq_ff[SQRT_N].valid |->
         ((REM_W+1)'(sq_ff[SQRT_N].rem) <= (REM_W+1)'({sq_ff[SQRT_N].root, 1'b0})))
      else $error("square root remainder too large");
`endif

endmodule
